// ===== hdl/ffsa_pkg.sv =====
// Shared types, constants and codes of the first-fit segment allocator.
`timescale 1ns / 1ps
package ffsa_pkg;

	localparam int ARENA_UNITS  = 4096;
	localparam int HEADER_UNITS = 2;
	localparam int UNIT_SHIFT   = 4;
	localparam int ADDR_W       = 12;
	localparam int PTR_W        = ADDR_W + 1;
	localparam int LEN_W        = 12;
	localparam int UNITS_W      = 14;
	localparam int SIZE_W       = 17;
	localparam int THR_W        = 7;
	localparam logic [THR_W-1:0] THR_RESET = 7'd6;

	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_FREE    = 2'd1;
	localparam logic [1:0] CMD_REALLOC = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_IGNORED  = 2'd2;

	typedef struct packed {
		logic [1:0]        command;
		logic [ADDR_W-1:0] buffer_offset;
		logic [SIZE_W-1:0] size_bytes;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [ADDR_W-1:0] granted_offset;
		logic [LEN_W-1:0]  granted_units;
		logic              moved;
		logic [LEN_W-1:0]  copy_units;
	} rsp_t;

	typedef struct packed {
		logic              valid;
		logic              used;
		logic [LEN_W-1:0]  len;
		logic [ADDR_W-1:0] prev;
	} hdr_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CLR, OP_TAKE, OP_LK_RD, OP_LK_CHK, OP_F_INIT, OP_F_RD, OP_F_CHK,
		OP_SP_DEC, OP_SP_WS, OP_SP_AFT, OP_G_RD, OP_G_CHK, OP_R_RD, OP_R_CHK,
		OP_R_NRD, OP_R_NCHK, OP_R_PRD, OP_R_PCHK, OP_J_RD, OP_J_CHK, OP_J_WS,
		OP_J_WJ, OP_FIN
	} op_t;

	typedef enum logic [2:0] {
		RES_IGN, RES_FREED, RES_NOSP, RES_INPL, RES_GROW, RES_FIT
	} res_kind_t;

	typedef struct packed {
		op_t       op;
		logic      res_load;
		res_kind_t res_kind;
	} ctl_t;

	typedef struct packed {
		logic       clr_done;
		logic [1:0] cmd;
		logic       hok;
		logic       inplace;
		logic       live;
		logic       nfree;
		logic       fit_ok;
		logic       grow_ok;
		logic       s_zero;
		logic       out_free;
	} sts_t;

endpackage

// ===== hdl/ffsa_dp.sv =====
// Datapath of the allocator: header memory, working registers and result register.
`timescale 1ns / 1ps
module ffsa_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ffsa_pkg::ctl_t              ctl,
	output ffsa_pkg::sts_t              sts,
	input  ffsa_pkg::req_t              req_data,
	input  logic                        cfg_we,
	input  logic [ffsa_pkg::THR_W-1:0]  cfg_wdata,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output ffsa_pkg::rsp_t              rsp_data
);

	localparam int AW = ffsa_pkg::ADDR_W;
	localparam int PW = ffsa_pkg::PTR_W;
	localparam int LW = ffsa_pkg::LEN_W;
	localparam int UW = ffsa_pkg::UNITS_W;
	localparam int SW = ffsa_pkg::SIZE_W;
	localparam int TW = ffsa_pkg::THR_W;

	ffsa_pkg::hdr_t mem [ffsa_pkg::ARENA_UNITS];
	ffsa_pkg::hdr_t rdata_q, wdata, reset_hdr;
	logic           re, we;
	logic [PW-1:0]  raddr, rd_addr_q;
	logic [AW-1:0]  waddr;

	logic [AW-1:0]  clr_q;
	logic [TW-1:0]  thr_q;
	logic [1:0]     cmd_q;
	logic [AW-1:0]  off_q, h_q, s_q, sprev_q, j_q, g_q;
	logic [UW-1:0]  units_q;
	logic           hok_q, sused_q, split_q;
	logic [LW-1:0]  hlen_q, hprev_q, slen_q, jlen_q;
	logic [PW-1:0]  cur_q;
	logic [AW-1:0]  aux_q;
	logic           out_valid_q;
	ffsa_pkg::rsp_t out_q, res_q, res_n;

	logic [SW:0]    size_sum;
	logic [UW-1:0]  units_n;
	logic           live;
	logic [TW-1:0]  thr_eff;
	logic [UW+1:0]  ns;
	logic [LW-1:0]  rest;
	logic           do_split;
	logic [LW-1:0]  jsum;
	logic [UW-1:0]  grow_sum;

	function automatic logic [PW-1:0] next_of(input logic [AW-1:0] a, input logic [LW-1:0] l);
		next_of = {1'b0, a} + PW'(ffsa_pkg::HEADER_UNITS) + {1'b0, l};
	endfunction

	assign size_sum  = {1'b0, req_data.size_bytes} + (SW+1)'((1 << ffsa_pkg::UNIT_SHIFT) - 1);
	assign units_n   = UW'(size_sum[SW:ffsa_pkg::UNIT_SHIFT]);
	assign live      = !rd_addr_q[PW-1] && rdata_q.valid;
	assign thr_eff   = (thr_q < TW'(ffsa_pkg::HEADER_UNITS)) ? TW'(ffsa_pkg::HEADER_UNITS) : thr_q;
	assign ns        = (UW+2)'(s_q) + (UW+2)'(ffsa_pkg::HEADER_UNITS) + (UW+2)'(units_q);
	assign rest      = slen_q - LW'(units_q);
	assign do_split  = (UW'(slen_q) >= units_q) && (rest >= LW'(thr_eff))
		&& (ns < (UW+2)'(ffsa_pkg::ARENA_UNITS));
	assign jsum      = slen_q + jlen_q + LW'(ffsa_pkg::HEADER_UNITS);
	assign grow_sum  = UW'(hlen_q) + UW'(ffsa_pkg::HEADER_UNITS) + UW'(rdata_q.len);

	always_comb begin
		reset_hdr       = '0;
		reset_hdr.valid = 1'b1;
		reset_hdr.len   = LW'(ffsa_pkg::ARENA_UNITS - ffsa_pkg::HEADER_UNITS);
	end

	always_comb begin
		re    = 1'b0;
		raddr = '0;
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		case (ctl.op)
			ffsa_pkg::OP_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = (clr_q == '0) ? reset_hdr : '0;
			end
			ffsa_pkg::OP_LK_RD, ffsa_pkg::OP_R_RD: begin
				re    = 1'b1;
				raddr = {1'b0, h_q};
			end
			ffsa_pkg::OP_F_RD: begin
				re    = 1'b1;
				raddr = cur_q;
			end
			ffsa_pkg::OP_SP_DEC: begin
				if (do_split) begin
					we    = 1'b1;
					waddr = ns[AW-1:0];
					wdata = '{valid: 1'b1, used: 1'b0,
						len: rest - LW'(ffsa_pkg::HEADER_UNITS), prev: s_q};
				end
			end
			ffsa_pkg::OP_SP_WS: begin
				we    = 1'b1;
				waddr = s_q;
				wdata = '{valid: 1'b1, used: sused_q, len: slen_q, prev: sprev_q};
				re    = 1'b1;
				raddr = cur_q;
			end
			ffsa_pkg::OP_SP_AFT: begin
				if (split_q && live) begin
					we         = 1'b1;
					waddr      = rd_addr_q[AW-1:0];
					wdata      = rdata_q;
					wdata.prev = aux_q;
				end
			end
			ffsa_pkg::OP_G_RD: begin
				re    = 1'b1;
				raddr = next_of(h_q, hlen_q);
			end
			ffsa_pkg::OP_R_CHK: begin
				we    = 1'b1;
				waddr = h_q;
				wdata = '{valid: 1'b1, used: 1'b0, len: rdata_q.len, prev: rdata_q.prev};
			end
			ffsa_pkg::OP_R_NRD: begin
				re    = 1'b1;
				raddr = next_of(s_q, slen_q);
			end
			ffsa_pkg::OP_R_PRD: begin
				re    = 1'b1;
				raddr = {1'b0, sprev_q};
			end
			ffsa_pkg::OP_J_RD: begin
				re    = 1'b1;
				raddr = next_of(j_q, jlen_q);
			end
			ffsa_pkg::OP_J_CHK: begin
				if (live) begin
					we         = 1'b1;
					waddr      = rd_addr_q[AW-1:0];
					wdata      = rdata_q;
					wdata.prev = s_q;
				end
			end
			ffsa_pkg::OP_J_WS: begin
				we    = 1'b1;
				waddr = s_q;
				wdata = '{valid: 1'b1, used: sused_q, len: jsum, prev: sprev_q};
			end
			ffsa_pkg::OP_J_WJ: begin
				we    = 1'b1;
				waddr = j_q;
				wdata = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q   <= mem[raddr[AW-1:0]];
			rd_addr_q <= raddr;
		end
	end

	always_comb begin
		res_n = '0;
		case (ctl.res_kind)
			ffsa_pkg::RES_IGN:   res_n.status = ffsa_pkg::ST_IGNORED;
			ffsa_pkg::RES_FREED: res_n.status = ffsa_pkg::ST_OK;
			ffsa_pkg::RES_NOSP:  res_n.status = ffsa_pkg::ST_NO_SPACE;
			ffsa_pkg::RES_INPL: begin
				res_n.status         = ffsa_pkg::ST_OK;
				res_n.granted_offset = off_q;
				res_n.granted_units  = hlen_q;
			end
			ffsa_pkg::RES_GROW: begin
				res_n.status         = ffsa_pkg::ST_OK;
				res_n.granted_offset = off_q;
				res_n.granted_units  = slen_q;
			end
			ffsa_pkg::RES_FIT: begin
				res_n.status         = ffsa_pkg::ST_OK;
				res_n.granted_offset = g_q + AW'(ffsa_pkg::HEADER_UNITS);
				res_n.granted_units  = slen_q;
				res_n.moved          = (cmd_q == ffsa_pkg::CMD_REALLOC);
				res_n.copy_units     = (cmd_q == ffsa_pkg::CMD_REALLOC) ? hlen_q : '0;
			end
			default: res_n.status = ffsa_pkg::ST_IGNORED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			thr_q       <= ffsa_pkg::THR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.op == ffsa_pkg::OP_CLR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (ctl.op == ffsa_pkg::OP_FIN) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			res_q <= res_n;
		end
		case (ctl.op)
			ffsa_pkg::OP_TAKE: begin
				cmd_q   <= req_data.command;
				off_q   <= req_data.buffer_offset;
				h_q     <= req_data.buffer_offset - AW'(ffsa_pkg::HEADER_UNITS);
				units_q <= units_n;
			end
			ffsa_pkg::OP_LK_CHK: begin
				hok_q   <= (off_q >= AW'(ffsa_pkg::HEADER_UNITS)) && rdata_q.valid
					&& rdata_q.used;
				hlen_q  <= rdata_q.len;
				hprev_q <= rdata_q.prev;
			end
			ffsa_pkg::OP_F_INIT: cur_q <= '0;
			ffsa_pkg::OP_F_CHK: begin
				s_q     <= rd_addr_q[AW-1:0];
				g_q     <= rd_addr_q[AW-1:0];
				slen_q  <= rdata_q.len;
				sprev_q <= rdata_q.prev;
				sused_q <= 1'b1;
				cur_q   <= next_of(rd_addr_q[AW-1:0], rdata_q.len);
			end
			ffsa_pkg::OP_SP_DEC: begin
				split_q <= do_split;
				aux_q   <= ns[AW-1:0];
				cur_q   <= next_of(s_q, slen_q);
				if (do_split) begin
					slen_q <= LW'(units_q);
				end
			end
			ffsa_pkg::OP_G_CHK: begin
				s_q     <= h_q;
				slen_q  <= hlen_q;
				sprev_q <= hprev_q;
				sused_q <= 1'b1;
				j_q     <= rd_addr_q[AW-1:0];
				jlen_q  <= rdata_q.len;
			end
			ffsa_pkg::OP_R_CHK: begin
				s_q     <= h_q;
				slen_q  <= rdata_q.len;
				sprev_q <= rdata_q.prev;
				sused_q <= 1'b0;
			end
			ffsa_pkg::OP_R_NCHK: begin
				j_q    <= rd_addr_q[AW-1:0];
				jlen_q <= rdata_q.len;
			end
			ffsa_pkg::OP_R_PCHK: begin
				j_q     <= s_q;
				jlen_q  <= slen_q;
				s_q     <= rd_addr_q[AW-1:0];
				slen_q  <= rdata_q.len;
				sprev_q <= rdata_q.prev;
				sused_q <= rdata_q.used;
			end
			ffsa_pkg::OP_J_WS: slen_q <= jsum;
			ffsa_pkg::OP_FIN:  out_q <= res_q;
			default: begin
			end
		endcase
	end

	always_comb begin
		sts.clr_done = (clr_q == '1);
		sts.cmd      = cmd_q;
		sts.hok      = hok_q;
		sts.inplace  = (units_q <= UW'(hlen_q));
		sts.live     = live;
		sts.nfree    = live && !rdata_q.used;
		sts.fit_ok   = live && !rdata_q.used && (UW'(rdata_q.len) >= units_q);
		sts.grow_ok  = live && !rdata_q.used && (grow_sum >= units_q);
		sts.s_zero   = (s_q == '0);
		sts.out_free = !out_valid_q || !rsp_stall;
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

endmodule

// ===== hdl/ffsa_ctrl.sv =====
// Controller of the allocator: sequences header reads and writes for each request.
`timescale 1ns / 1ps
module ffsa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ffsa_pkg::sts_t sts,
	output ffsa_pkg::ctl_t ctl
);

	typedef enum logic [24:0] {
		S_CLR    = 25'd1 << 0,
		S_IDLE   = 25'd1 << 1,
		S_LK_RD  = 25'd1 << 2,
		S_LK_CHK = 25'd1 << 3,
		S_DISP   = 25'd1 << 4,
		S_F_INIT = 25'd1 << 5,
		S_F_RD   = 25'd1 << 6,
		S_F_CHK  = 25'd1 << 7,
		S_SP_DEC = 25'd1 << 8,
		S_SP_WS  = 25'd1 << 9,
		S_SP_AFT = 25'd1 << 10,
		S_G_RD   = 25'd1 << 11,
		S_G_CHK  = 25'd1 << 12,
		S_R_RD   = 25'd1 << 13,
		S_R_CHK  = 25'd1 << 14,
		S_R_NRD  = 25'd1 << 15,
		S_R_NCHK = 25'd1 << 16,
		S_R_P    = 25'd1 << 17,
		S_R_PCHK = 25'd1 << 18,
		S_J_RD   = 25'd1 << 19,
		S_J_CHK  = 25'd1 << 20,
		S_J_WS   = 25'd1 << 21,
		S_J_WJ   = 25'd1 << 22,
		S_FIN    = 25'd1 << 23,
		S_SPARE  = 25'd1 << 24
	} state_t;

	typedef enum logic [1:0] {
		JR_GROW, JR_NEXT, JR_PREV
	} jret_t;

	state_t state_q, state_n;
	jret_t  jret_q, jret_n;
	logic   grow_q, grow_n;

	always_comb begin
		state_n      = state_q;
		jret_n       = jret_q;
		grow_n       = grow_q;
		ctl.op       = ffsa_pkg::OP_NONE;
		ctl.res_load = 1'b0;
		ctl.res_kind = ffsa_pkg::RES_IGN;
		case (state_q)
			S_CLR: begin
				ctl.op = ffsa_pkg::OP_CLR;
				if (sts.clr_done) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					ctl.op  = ffsa_pkg::OP_TAKE;
					state_n = S_LK_RD;
				end
			end
			S_LK_RD: begin
				ctl.op  = ffsa_pkg::OP_LK_RD;
				state_n = S_LK_CHK;
			end
			S_LK_CHK: begin
				ctl.op  = ffsa_pkg::OP_LK_CHK;
				state_n = S_DISP;
			end
			S_DISP: begin
				ctl.res_load = 1'b1;
				state_n      = S_FIN;
				case (sts.cmd)
					ffsa_pkg::CMD_ALLOC: begin
						ctl.res_load = 1'b0;
						grow_n       = 1'b0;
						state_n      = S_F_INIT;
					end
					ffsa_pkg::CMD_FREE: begin
						if (sts.hok) begin
							ctl.res_kind = ffsa_pkg::RES_FREED;
							state_n      = S_R_RD;
						end
					end
					ffsa_pkg::CMD_REALLOC: begin
						if (sts.hok && sts.inplace) begin
							ctl.res_kind = ffsa_pkg::RES_INPL;
						end else if (sts.hok) begin
							ctl.res_load = 1'b0;
							state_n      = S_G_RD;
						end
					end
					default: begin
					end
				endcase
			end
			S_F_INIT: begin
				ctl.op  = ffsa_pkg::OP_F_INIT;
				state_n = S_F_RD;
			end
			S_F_RD: begin
				ctl.op  = ffsa_pkg::OP_F_RD;
				state_n = S_F_CHK;
			end
			S_F_CHK: begin
				ctl.op = ffsa_pkg::OP_F_CHK;
				if (!sts.live) begin
					ctl.res_load = 1'b1;
					ctl.res_kind = ffsa_pkg::RES_NOSP;
					state_n      = S_FIN;
				end else if (sts.fit_ok) begin
					state_n = S_SP_DEC;
				end else begin
					state_n = S_F_RD;
				end
			end
			S_SP_DEC: begin
				ctl.op  = ffsa_pkg::OP_SP_DEC;
				state_n = S_SP_WS;
			end
			S_SP_WS: begin
				ctl.op  = ffsa_pkg::OP_SP_WS;
				state_n = S_SP_AFT;
			end
			S_SP_AFT: begin
				ctl.op       = ffsa_pkg::OP_SP_AFT;
				ctl.res_load = 1'b1;
				ctl.res_kind = grow_q ? ffsa_pkg::RES_GROW : ffsa_pkg::RES_FIT;
				if (!grow_q && sts.cmd == ffsa_pkg::CMD_REALLOC) begin
					state_n = S_R_RD;
				end else begin
					state_n = S_FIN;
				end
			end
			S_G_RD: begin
				ctl.op  = ffsa_pkg::OP_G_RD;
				state_n = S_G_CHK;
			end
			S_G_CHK: begin
				ctl.op = ffsa_pkg::OP_G_CHK;
				if (sts.grow_ok) begin
					jret_n  = JR_GROW;
					state_n = S_J_RD;
				end else begin
					grow_n  = 1'b0;
					state_n = S_F_INIT;
				end
			end
			S_R_RD: begin
				ctl.op  = ffsa_pkg::OP_R_RD;
				state_n = S_R_CHK;
			end
			S_R_CHK: begin
				ctl.op  = ffsa_pkg::OP_R_CHK;
				state_n = S_R_NRD;
			end
			S_R_NRD: begin
				ctl.op  = ffsa_pkg::OP_R_NRD;
				state_n = S_R_NCHK;
			end
			S_R_NCHK: begin
				ctl.op = ffsa_pkg::OP_R_NCHK;
				if (sts.nfree) begin
					jret_n  = JR_NEXT;
					state_n = S_J_RD;
				end else begin
					state_n = S_R_P;
				end
			end
			S_R_P: begin
				if (sts.s_zero) begin
					state_n = S_FIN;
				end else begin
					ctl.op  = ffsa_pkg::OP_R_PRD;
					state_n = S_R_PCHK;
				end
			end
			S_R_PCHK: begin
				if (sts.nfree) begin
					ctl.op  = ffsa_pkg::OP_R_PCHK;
					jret_n  = JR_PREV;
					state_n = S_J_RD;
				end else begin
					state_n = S_FIN;
				end
			end
			S_J_RD: begin
				ctl.op  = ffsa_pkg::OP_J_RD;
				state_n = S_J_CHK;
			end
			S_J_CHK: begin
				ctl.op  = ffsa_pkg::OP_J_CHK;
				state_n = S_J_WS;
			end
			S_J_WS: begin
				ctl.op  = ffsa_pkg::OP_J_WS;
				state_n = S_J_WJ;
			end
			S_J_WJ: begin
				ctl.op = ffsa_pkg::OP_J_WJ;
				case (jret_q)
					JR_GROW: begin
						grow_n  = 1'b1;
						state_n = S_SP_DEC;
					end
					JR_NEXT: state_n = S_R_P;
					default: state_n = S_FIN;
				endcase
			end
			S_FIN: begin
				if (sts.out_free) begin
					ctl.op  = ffsa_pkg::OP_FIN;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			jret_q  <= JR_GROW;
			grow_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			jret_q  <= jret_n;
			grow_q  <= grow_n;
		end
	end

	assign req_stall = (state_q != S_IDLE);

endmodule

// ===== hdl/first_fit_segment_allocator.sv =====
// Allocate walks the segment headers first-fit; free merges with free neighbours.
// Reallocate may add a walk and a release.
// One request at a time: req_stall stays high while a request walks the header memory.
// Reset: a clearing pass rewrites all 4096 header entries, requests stall.
// The split threshold resets to 6 units; configuration writes are taken at any time.
`timescale 1ns / 1ps
module first_fit_segment_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ffsa_pkg::THR_W-1:0]  cfg_wdata,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  ffsa_pkg::req_t              req_data,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output ffsa_pkg::rsp_t              rsp_data
);

	ffsa_pkg::ctl_t ctl;
	ffsa_pkg::sts_t sts;

	ffsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	ffsa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.req_data  (req_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while a request was still in work");

	a_no_grant_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != ffsa_pkg::ST_OK |->
			rsp_data.granted_units == '0 && !rsp_data.moved && rsp_data.copy_units == '0)
		else $error("failed request carries grant fields");

	a_moved_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.moved |-> rsp_data.status == ffsa_pkg::ST_OK)
		else $error("moved buffer reported without success");

endmodule

// ===== bench/first_fit_segment_allocator_tb.sv =====
// Self-checking testbench for the first-fit segment allocator with split, merge and move.
`timescale 1ns / 1ps
module first_fit_segment_allocator_tb;

	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	localparam int SEG_LIMIT = ffsa_pkg::ARENA_UNITS;
	localparam int HOLD_CYCLES = 400;

	logic clk, arst_n, cfg_we, req_valid, req_stall, rsp_valid, rsp_stall;
	logic [ffsa_pkg::THR_W-1:0] cfg_wdata;
	ffsa_pkg::req_t req_data;
	ffsa_pkg::rsp_t rsp_data;

	first_fit_segment_allocator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// Shadow copy of the segment headers.
	bit seg_valid [SEG_LIMIT];
	bit seg_used [SEG_LIMIT];
	int unsigned seg_len [SEG_LIMIT];
	int unsigned seg_prev [SEG_LIMIT];
	int unsigned thr_units;

	ffsa_pkg::rsp_t grant_q[$];
	int unsigned live_bufs[$];
	int errors = 0;
	int snd_idle_pct, rcv_idle_pct;
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;

	function automatic int unsigned seg_end(int unsigned h);
		return h + ffsa_pkg::HEADER_UNITS + seg_len[h];
	endfunction

	function automatic bit is_live(int unsigned h);
		return h < SEG_LIMIT && seg_valid[h];
	endfunction

	function automatic void absorb_next(int unsigned s);
		int unsigned j, nn;
		j = seg_end(s);
		if (!is_live(j))
			return;
		nn = seg_end(j);
		if (is_live(nn))
			seg_prev[nn] = s;
		seg_len[s] += seg_len[j] + ffsa_pkg::HEADER_UNITS;
		seg_valid[j] = 0;
		seg_used[j] = 0;
	endfunction

	function automatic void carve_tail(int unsigned s, int unsigned units);
		int unsigned thr, rest, ns, nxt;
		thr = (thr_units < ffsa_pkg::HEADER_UNITS) ? ffsa_pkg::HEADER_UNITS : thr_units;
		if (seg_len[s] < units)
			return;
		rest = seg_len[s] - units;
		if (rest < thr)
			return;
		nxt = seg_end(s);
		ns = s + ffsa_pkg::HEADER_UNITS + units;
		if (ns >= SEG_LIMIT)
			return;
		seg_valid[ns] = 1;
		seg_used[ns] = 0;
		seg_prev[ns] = s;
		seg_len[ns] = rest - ffsa_pkg::HEADER_UNITS;
		seg_len[s] = units;
		if (is_live(nxt))
			seg_prev[nxt] = ns;
	endfunction

	function automatic int unsigned first_fit(int unsigned units);
		int unsigned h;
		h = 0;
		while (is_live(h)) begin
			if (!seg_used[h] && seg_len[h] >= units) begin
				carve_tail(h, units);
				seg_used[h] = 1;
				return h;
			end
			h = seg_end(h);
		end
		return SEG_LIMIT;
	endfunction

	function automatic void release_seg(int unsigned h);
		int unsigned n, p;
		seg_used[h] = 0;
		n = seg_end(h);
		if (is_live(n) && !seg_used[n])
			absorb_next(h);
		if (h != 0) begin
			p = seg_prev[h];
			if (is_live(p) && !seg_used[p])
				absorb_next(p);
		end
	endfunction

	function automatic ffsa_pkg::rsp_t predict_grant(ffsa_pkg::req_t r);
		ffsa_pkg::rsp_t o;
		int unsigned units, h, g, n;
		bit ok;
		o = '0;
		o.status = ffsa_pkg::ST_IGNORED;
		units = (int'(r.size_bytes) + 15) / 16;
		h = SEG_LIMIT;
		ok = 0;
		if (r.buffer_offset >= ffsa_pkg::HEADER_UNITS) begin
			h = int'(r.buffer_offset) - ffsa_pkg::HEADER_UNITS;
			ok = is_live(h);
		end
		case (r.command)
			ffsa_pkg::CMD_ALLOC: begin
				g = first_fit(units);
				if (g < SEG_LIMIT) begin
					o.status = ffsa_pkg::ST_OK;
					o.granted_offset = ffsa_pkg::ADDR_W'(g + ffsa_pkg::HEADER_UNITS);
					o.granted_units = ffsa_pkg::LEN_W'(seg_len[g]);
				end else
					o.status = ffsa_pkg::ST_NO_SPACE;
			end
			ffsa_pkg::CMD_FREE: begin
				if (ok && seg_used[h]) begin
					release_seg(h);
					o.status = ffsa_pkg::ST_OK;
				end
			end
			ffsa_pkg::CMD_REALLOC: begin
				if (ok && seg_used[h]) begin
					n = seg_end(h);
					if (units <= seg_len[h]) begin
						o.status = ffsa_pkg::ST_OK;
						o.granted_offset = r.buffer_offset;
						o.granted_units = ffsa_pkg::LEN_W'(seg_len[h]);
					end else if (is_live(n) && !seg_used[n] &&
							seg_len[h] + ffsa_pkg::HEADER_UNITS + seg_len[n] >= units) begin
						absorb_next(h);
						carve_tail(h, units);
						o.status = ffsa_pkg::ST_OK;
						o.granted_offset = r.buffer_offset;
						o.granted_units = ffsa_pkg::LEN_W'(seg_len[h]);
					end else begin
						g = first_fit(units);
						if (g < SEG_LIMIT) begin
							o.status = ffsa_pkg::ST_OK;
							o.granted_offset = ffsa_pkg::ADDR_W'(g + ffsa_pkg::HEADER_UNITS);
							o.granted_units = ffsa_pkg::LEN_W'(seg_len[g]);
							o.moved = 1'b1;
							o.copy_units = ffsa_pkg::LEN_W'(seg_len[h]);
							release_seg(h);
						end else
							o.status = ffsa_pkg::ST_NO_SPACE;
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic void track_buffers(ffsa_pkg::req_t r, ffsa_pkg::rsp_t e);
		int idx[$];
		if (e.status != ffsa_pkg::ST_OK)
			return;
		if (r.command == ffsa_pkg::CMD_ALLOC)
			live_bufs.push_back(int'(e.granted_offset));
		else if (r.command == ffsa_pkg::CMD_FREE ||
				(r.command == ffsa_pkg::CMD_REALLOC && e.moved)) begin
			idx = live_bufs.find_first_index(x) with (x == r.buffer_offset);
			if (idx.size() > 0)
				live_bufs.delete(idx[0]);
			if (r.command == ffsa_pkg::CMD_REALLOC)
				live_bufs.push_back(int'(e.granted_offset));
		end
	endfunction

	task automatic send_request(input logic [1:0] cmd, input int unsigned off,
			input int unsigned bytes);
		ffsa_pkg::req_t r;
		ffsa_pkg::rsp_t e;
		r.command = cmd;
		r.buffer_offset = off[ffsa_pkg::ADDR_W-1:0];
		r.size_bytes = bytes[ffsa_pkg::SIZE_W-1:0];
		if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do @(posedge clk); while (req_stall);
		e = predict_grant(r);
		grant_q.push_back(e);
		track_buffers(r, e);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		wait (grant_q.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_threshold(input int unsigned v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v[ffsa_pkg::THR_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_units = v & 7'h7F;
	endtask

	function automatic int unsigned pick_size();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 80)
			return $urandom_range(0, 400);
		else if (p < 95)
			return $urandom_range(0, 4000);
		return $urandom_range(0, 17'h1FFFF);
	endfunction

	function automatic int unsigned pick_live();
		if (live_bufs.size() == 0 || $urandom_range(9) == 0)
			return $urandom_range(0, 4095);
		return live_bufs[$urandom_range(0, live_bufs.size() - 1)];
	endfunction

	task automatic random_burst(input int n);
		int unsigned p;
		repeat (n) begin
			p = $urandom_range(99);
			if (live_bufs.size() > 60 && p < 45)
				p = 60;
			if (live_bufs.size() == 0 || p < 45)
				send_request(ffsa_pkg::CMD_ALLOC, $urandom_range(0, 4095), pick_size());
			else if (p < 75)
				send_request(ffsa_pkg::CMD_FREE, pick_live(), $urandom_range(0, 17'h1FFFF));
			else if (p < 93)
				send_request(ffsa_pkg::CMD_REALLOC, pick_live(), pick_size());
			else
				send_request(2'($urandom_range(0, 3)), $urandom_range(0, 4095),
					$urandom_range(0, 17'h1FFFF));
		end
	endtask

	task automatic release_all();
		while (live_bufs.size() > 0)
			send_request(ffsa_pkg::CMD_FREE, live_bufs[0], 0);
	endtask

	task automatic test_directed();
		int unsigned a, b, c;
		send_request(ffsa_pkg::CMD_ALLOC, 0, 65536);
		send_request(ffsa_pkg::CMD_ALLOC, 4095, 17'h1FFFF);
		send_request(ffsa_pkg::CMD_ALLOC, 0, 65504);
		release_all();
		send_request(ffsa_pkg::CMD_ALLOC, 0, 0);
		send_request(ffsa_pkg::CMD_ALLOC, 0, 1);
		send_request(ffsa_pkg::CMD_ALLOC, 0, 16);
		send_request(ffsa_pkg::CMD_ALLOC, 0, 17);
		a = live_bufs[0]; b = live_bufs[1]; c = live_bufs[2];
		send_request(ffsa_pkg::CMD_FREE, b, 0);
		send_request(ffsa_pkg::CMD_FREE, b, 0);
		send_request(ffsa_pkg::CMD_REALLOC, b, 32);
		send_request(ffsa_pkg::CMD_FREE, 0, 0);
		send_request(ffsa_pkg::CMD_FREE, 1, 0);
		send_request(ffsa_pkg::CMD_REALLOC, 4095, 16);
		send_request(CMD_UNKNOWN, c, 16);
		send_request(ffsa_pkg::CMD_REALLOC, c, 0);
		send_request(ffsa_pkg::CMD_REALLOC, a, 200);
		send_request(ffsa_pkg::CMD_REALLOC, c, 2000);
		send_request(ffsa_pkg::CMD_REALLOC, live_bufs[0], 65536);
		release_all();
		drain_results();
	endtask

	task automatic test_threshold_sweep();
		int unsigned levels [6] = '{0, 1, 64, 127, 2, 6};
		foreach (levels[i]) begin
			write_threshold(levels[i]);
			random_burst(50);
		end
		drain_results();
	endtask

	task automatic test_random_mix();
		snd_idle_pct = 19; rcv_idle_pct = 69;
		random_burst(550);
		snd_idle_pct = 69; rcv_idle_pct = 19;
		random_burst(550);
		snd_idle_pct = 0; rcv_idle_pct = 0;
		random_burst(450);
		drain_results();
	endtask

	task automatic test_backpressure();
		snd_idle_pct = 0; rcv_idle_pct = 0;
		@(posedge clk);
		hold_token = hold_token + 1;
		random_burst(40);
		drain_results();
		random_burst(20);
		drain_results();
	endtask

	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES - 1;
			rsp_stall <= 1'b1;
		end else if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else
			rsp_stall <= (rcv_idle_pct > 0) && ($urandom_range(99) < rcv_idle_pct);
	end

	always @(posedge clk) begin
		ffsa_pkg::rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (grant_q.size() == 0) begin
				$display("%0t: unexpected result %p", $time, rsp_data);
				errors++;
			end else begin
				e = grant_q.pop_front();
				if (rsp_data.status !== e.status ||
						rsp_data.granted_offset !== e.granted_offset ||
						rsp_data.granted_units !== e.granted_units ||
						rsp_data.moved !== e.moved || rsp_data.copy_units !== e.copy_units) begin
					$display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
					errors++;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < SEG_LIMIT; i++) begin
			seg_valid[i] = 0; seg_used[i] = 0; seg_len[i] = 0; seg_prev[i] = 0;
		end
		seg_valid[0] = 1;
		seg_len[0] = ffsa_pkg::ARENA_UNITS - ffsa_pkg::HEADER_UNITS;
		thr_units = ffsa_pkg::THR_RESET;
		snd_idle_pct = 0; rcv_idle_pct = 0;
		arst_n <= 1'b0; cfg_we <= 1'b0; cfg_wdata <= '0;
		req_valid <= 1'b0; req_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_threshold_sweep();
		test_random_mix();
		test_backpressure();
		drain_results();
		if (errors == 0)
			$display("first_fit_segment_allocator_tb: PASS");
		else
			$display("first_fit_segment_allocator_tb: FAIL");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("first_fit_segment_allocator_tb: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/ffsa_pkg.sv
hdl/ffsa_dp.sv
hdl/ffsa_ctrl.sv
hdl/first_fit_segment_allocator.sv
bench/first_fit_segment_allocator_tb.sv
